>>> rtl/core/half_float_xor_delta_decoder_defines.svh
// Assertion helpers for the half float XOR delta decoder.
`ifndef HALF_FLOAT_XOR_DELTA_DECODER_DEFINES_SVH
`define HALF_FLOAT_XOR_DELTA_DECODER_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define HFXD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication outside reset.
`define HFXD_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

>>> rtl/core/hfxd_pkg.sv
package hfxd_pkg;

    localparam int MAX_VALUES_DEF = 1024;
    localparam int BYTE_BITS      = 8;
    localparam int LEN_W          = 11;
    localparam int POS_W          = 10;

    localparam logic [0:0] KIND_LOAD  = 1'b0;
    localparam logic [0:0] KIND_DELTA = 1'b1;

    localparam logic [0:0] REG_SNAPSHOT_LENGTH = 1'b0;

    typedef struct packed {
        logic [0:0]  kind;
        logic [31:0] seed_value;
        logic [7:0]  delta_low_byte;
        logic [7:0]  delta_high_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0]      value_single;
        logic [15:0]      value_half;
        logic [POS_W-1:0] position;
        logic             last_of_snapshot;
    } out_beat_t;

    // Round single to half, nearest even.
    function automatic logic [15:0] single_to_half(input logic [31:0] x);
        logic [15:0] sgn;
        logic [7:0]  ex;
        logic [22:0] mant;
        logic [23:0] m;
        logic [4:0]  shift;
        logic [23:0] h;
        logic [23:0] rem;
        logic [23:0] hlf;
        logic [15:0] res;
        sgn  = {x[31], 15'd0};
        ex   = x[30:23];
        mant = x[22:0];
        m    = {1'b1, mant};
        shift = 5'd0;
        h = 24'd0;
        rem = 24'd0;
        hlf = 24'd0;
        if (ex == 8'hFF) begin
            if (mant != 23'd0) res = sgn | 16'h7E00 | {6'd0, mant[22:13]};
            else res = sgn | 16'h7C00;
        end else if (ex >= 8'd143) begin
            res = sgn | 16'h7C00;
        end else if (ex <= 8'd112) begin
            if (ex < 8'd102) res = sgn;
            else begin
                shift = 5'(8'd126 - ex);
                h   = m >> shift;
                rem = m & ((24'd1 << shift) - 24'd1);
                hlf = 24'd1 << (shift - 5'd1);
                if (rem > hlf || (rem == hlf && h[0])) h = h + 24'd1;
                res = sgn | h[15:0];
            end
        end else begin
            h = {9'd0, 5'(ex - 8'd112), mant[22:13]};
            if (mant[12:0] > 13'h1000 || (mant[12:0] == 13'h1000 && h[0])) h = h + 24'd1;
            res = sgn | h[15:0];
        end
        return res;
    endfunction

    // Exact widening of half to single.
    function automatic logic [31:0] half_to_single(input logic [15:0] v);
        logic [4:0] ex;
        logic [9:0] mant;
        logic [7:0] e;
        logic [31:0] res;
        ex = v[14:10];
        mant = v[9:0];
        e = 8'd113;
        if (ex == 5'h1F) res = {v[15], 8'hFF, mant, 13'd0};
        else if (ex == 5'd0) begin
            if (mant == 10'd0) res = {v[15], 31'd0};
            else begin
                for (int i = 0; i < 10; i++) begin
                    if (!mant[9]) begin
                        mant = {mant[8:0], 1'b0};
                        e = e - 8'd1;
                    end
                end
                // one further shift moves the leading one out of the field
                mant = {mant[8:0], 1'b0};
                e = e - 8'd1;
                res = {v[15], e, mant, 13'd0};
            end
        end else res = {v[15], 8'({3'd0, ex} + 8'd112), mant, 13'd0};
        return res;
    endfunction

endpackage

>>> rtl/core/half_float_xor_delta_decoder.sv
// channel | handshake          | payload
// in      | in_valid/in_stall  | in_beat  (kind, seed, delta bytes)
// out     | out_valid/out_stall| out_beat (single, half, position, last)
// cfg     | APB psel/penable   | snapshot_length at address 0
//
// Three stages: count/round with state read issue, memory read-modify-write,
// widen. One beat per cycle sustained while out is unstalled; a delta beat
// passes the stage 1, stage 2 and output registers in turn. The state memory
// takes one read and one write per beat. Reset clears position counter,
// length (1024) and valids; memory is not cleared. A stall freezes the whole
// pipe; input stall follows out stall only when the output slot is full.
`include "half_float_xor_delta_decoder_defines.svh"
module half_float_xor_delta_decoder #(
    parameter int MAX_VALUES = hfxd_pkg::MAX_VALUES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  hfxd_pkg::in_beat_t   in_beat,
    output logic                 out_valid,
    input  logic                 out_stall,
    output hfxd_pkg::out_beat_t  out_beat,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    localparam int ADDR_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

    logic [hfxd_pkg::LEN_W-1:0] len_reg;
    logic adv, take;
    logic s1_v, s1_kind, s1_last, s2_v, s2_last;
    logic [15:0] s1_half, s2_recon;
    logic [ADDR_W-1:0] s0_slot, s1_slot;
    logic [hfxd_pkg::POS_W-1:0] s1_pos, s2_pos;
    logic out_v_reg;
    hfxd_pkg::out_beat_t out_reg;

    // Advance the pipe whenever the output slot is free or being taken.
    assign adv = !out_v_reg || !out_stall;
    assign in_stall = !adv;
    assign take = in_valid && adv;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == hfxd_pkg::REG_SNAPSHOT_LENGTH) ?
        {{(32-hfxd_pkg::LEN_W){1'b0}}, len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) len_reg <= hfxd_pkg::LEN_W'(1024);
        else if (psel && penable && pwrite && paddr[2] == hfxd_pkg::REG_SNAPSHOT_LENGTH)
            len_reg <= pwdata[hfxd_pkg::LEN_W-1:0];
    end

    hfxd_front #(.MAX_VALUES(MAX_VALUES), .ADDR_W(ADDR_W)) u_front (
        .clk(clk), .rst_n(rst_n), .adv(adv), .take(take), .beat(in_beat),
        .snapshot_length(len_reg), .rd_slot(s0_slot), .v_reg(s1_v), .kind_reg(s1_kind),
        .half_reg(s1_half), .slot_reg(s1_slot), .pos_reg(s1_pos), .last_reg(s1_last)
    );

    hfxd_store #(.MAX_VALUES(MAX_VALUES), .ADDR_W(ADDR_W)) u_store (
        .clk(clk), .rst_n(rst_n), .adv(adv), .rd_slot(s0_slot), .v_in(s1_v),
        .kind_in(s1_kind), .half_in(s1_half), .slot_in(s1_slot), .pos_in(s1_pos),
        .last_in(s1_last), .v_reg(s2_v), .recon_reg(s2_recon), .pos_reg(s2_pos),
        .last_reg(s2_last)
    );

    // Widen in the last stage and hold the beat for the consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_v_reg <= 1'b0;
        else if (adv) out_v_reg <= s2_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.value_single <= hfxd_pkg::half_to_single(s2_recon);
            out_reg.value_half <= s2_recon;
            out_reg.position <= s2_pos;
            out_reg.last_of_snapshot <= s2_last;
        end
    end

    assign out_valid = out_v_reg;
    assign out_beat = out_reg;

    `HFXD_ASSERT_NXT(a_hold, clk, rst_n, out_v_reg && out_stall, out_v_reg && $stable(out_reg))
    `HFXD_ASSERT_IMP(a_stall, clk, rst_n, in_stall, out_v_reg && out_stall)
    `HFXD_ASSERT_NXT(a_load_silent, clk, rst_n, adv && s1_v && s1_kind == hfxd_pkg::KIND_LOAD, !s2_v)
endmodule

>>> rtl/core/hfxd_front.sv
// Stage 1: position count and seed rounding.
module hfxd_front #(
    parameter int MAX_VALUES = hfxd_pkg::MAX_VALUES_DEF,
    parameter int ADDR_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        take,
    input  hfxd_pkg::in_beat_t          beat,
    input  logic [hfxd_pkg::LEN_W-1:0]  snapshot_length,
    output logic [ADDR_W-1:0]           rd_slot,
    output logic                        v_reg,
    output logic                        kind_reg,
    output logic [15:0]                 half_reg,
    output logic [ADDR_W-1:0]           slot_reg,
    output logic [hfxd_pkg::POS_W-1:0]  pos_reg,
    output logic                        last_reg
);
    localparam int CW = hfxd_pkg::POS_W + 1;
    logic [hfxd_pkg::POS_W-1:0] cnt_reg;
    logic [hfxd_pkg::LEN_W-1:0] len;
    logic [CW-1:0] len_c;
    logic last_next;
    logic [ADDR_W-1:0] slot_next;

    always_comb
    begin
        len = snapshot_length;
        if (len == '0) len = hfxd_pkg::LEN_W'(1);
        if (32'(len) > MAX_VALUES) len = hfxd_pkg::LEN_W'(MAX_VALUES);
        len_c = CW'(len);
        last_next = (CW'(cnt_reg) + CW'(1)) >= len_c;
        if (32'(cnt_reg) < MAX_VALUES) slot_next = ADDR_W'(cnt_reg);
        else slot_next = ADDR_W'(MAX_VALUES - 1);
    end

    // Issue the state read for the beat entering this stage.
    assign rd_slot = slot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v_reg <= 1'b0;
        end
        else
        begin
            if (take) cnt_reg <= last_next ? '0 : cnt_reg + 1'b1;
            if (adv) v_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg <= beat.kind;
            half_reg <= (beat.kind == hfxd_pkg::KIND_LOAD) ?
                hfxd_pkg::single_to_half(beat.seed_value) :
                {beat.delta_high_byte, beat.delta_low_byte};
            slot_reg <= slot_next;
            pos_reg <= cnt_reg;
            last_reg <= last_next;
        end
    end
endmodule

>>> rtl/core/hfxd_store.sv
// Stage 2: state memory with read-after-write forwarding.
module hfxd_store #(
    parameter int MAX_VALUES = hfxd_pkg::MAX_VALUES_DEF,
    parameter int ADDR_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [ADDR_W-1:0]           rd_slot,
    input  logic                        v_in,
    input  logic                        kind_in,
    input  logic [15:0]                 half_in,
    input  logic [ADDR_W-1:0]           slot_in,
    input  logic [hfxd_pkg::POS_W-1:0]  pos_in,
    input  logic                        last_in,
    output logic                        v_reg,
    output logic [15:0]                 recon_reg,
    output logic [hfxd_pkg::POS_W-1:0]  pos_reg,
    output logic                        last_reg
);
    logic [15:0] mem [MAX_VALUES];
    logic [15:0] rd_reg;
    logic [15:0] byp_data_reg;
    logic        byp_reg;
    logic [15:0] prev;
    logic [15:0] wr_data;

    // The read is registered when the beat enters stage 1; a write at that
    // same edge to the same slot is not in rd_reg, so take it from the bypass.
    always_comb
    begin
        prev = byp_reg ? byp_data_reg : rd_reg;
        wr_data = (kind_in == hfxd_pkg::KIND_LOAD) ? half_in : (half_in ^ prev);
    end

    always_ff @(posedge clk)
    begin
        if (adv && v_in) mem[slot_in] <= wr_data;
        if (adv)
        begin
            rd_reg <= mem[rd_slot];
            byp_data_reg <= wr_data;
            recon_reg <= wr_data;
            pos_reg <= pos_in;
            last_reg <= last_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
            byp_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in && (kind_in == hfxd_pkg::KIND_DELTA);
            byp_reg <= v_in && (slot_in == rd_slot);
        end
    end
endmodule
